// ===== hdl/smtp_command_line_parser_defines.svh =====
// Assertion macros shared by the SMTP command line parser RTL.
`ifndef SMTP_COMMAND_LINE_PARSER_DEFINES_SVH
`define SMTP_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SCLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SCLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sclp_pkg.sv =====
// Types, codes and command word tables for the SMTP command line parser.
`default_nettype none

package sclp_pkg;

  // Parse phases, one-hot.
  typedef enum logic [3:0] {
    PH_WORD   = 4'b0001,
    PH_SPACES = 4'b0010,
    PH_ARG    = 4'b0100,
    PH_CRSEEN = 4'b1000
  } phase_t;

  // Line status codes.
  localparam logic [1:0] ST_MORE     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;

  // Command codes.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_AUTH     = 4'd4;
  localparam logic [3:0] CMD_STARTTLS = 4'd12;

  // Configuration register indexes.
  localparam logic [0:0] REG_MAX_ARGS = 1'd0;
  localparam logic [0:0] REG_STARTTLS = 1'd1;

  // Delimiter characters.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Field widths and limits.
  localparam int unsigned ARG_LEN_FIELD_W = 12;
  localparam int unsigned NUM_FOUR_WORDS  = 11;
  localparam logic [3:0]  WORD_STORE_LEN  = 4'd8;
  localparam logic [3:0]  WORD_LEN_SAT    = 4'd15;
  localparam logic [3:0]  ARGS_SAT        = 4'd15;
  localparam logic [3:0]  SHORT_WORD_LEN  = 4'd4;
  localparam logic [3:0]  LONG_WORD_LEN   = 4'd8;

  // Four-letter commands; entry k has command code k+1.
  localparam logic [7:0] FOUR_WORDS [0:10][0:3] = '{
    '{"H", "E", "L", "O"}, '{"E", "H", "L", "O"}, '{"Q", "U", "I", "T"},
    '{"A", "U", "T", "H"}, '{"N", "O", "O", "P"}, '{"M", "A", "I", "L"},
    '{"R", "S", "E", "T"}, '{"R", "C", "P", "T"}, '{"V", "R", "F", "Y"},
    '{"E", "X", "P", "N"}, '{"H", "E", "L", "P"}
  };

  localparam logic [7:0] LONG_WORD [0:7] = '{"S", "T", "A", "R", "T", "T", "L", "S"};

  // Folds a lower-case ASCII letter to upper case.
  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic is_lower;
    is_lower = (c >= "a") && (c <= "z");
    return is_lower ? (c - 8'd32) : c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/smtp_command_line_parser.sv =====
// Top level of the SMTP command line parser: one byte in, one result word out.
//
//   Channel  Dir  Payload                                         Handshake
//   s_*      in   s_tdata[7:0] line_byte                          tvalid/tready
//   m_*      out  m_tuser status; m_tdata command, arg fields     tvalid/tready
//   cfg_*    in   cfg_index selects max_args / starttls_enable    cfg_we only
//
// Each byte is parsed in the cycle it is accepted and its result word sits in
// the output register from the next cycle on.
// The byte's state update and result come from one pass over the parser
// state and the eight stored command characters, compared in parallel.
// A new byte is accepted whenever the output register is empty or is being
// taken in the same cycle, so a stalled output stops input after one word.
// rst is synchronous and active high; it returns the parser to the command
// word phase with max_args at 10 and STARTTLS enabled.
`default_nettype none
`include "smtp_command_line_parser_defines.svh"

module smtp_command_line_parser #(
  parameter int unsigned MAX_ARG_LENGTH = 4095
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] line_byte
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [3:0] command, [4] arg_closed,
                                      // [16:5] arg_length, [20:17] arg_index
  output logic [1:0]       m_tuser,   // [1:0] status
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import sclp_pkg::*;

  localparam int unsigned ARG_LEN_W  = $clog2(MAX_ARG_LENGTH + 1);
  localparam int unsigned LEN_WIDE_W = ARG_LEN_W + ARG_LEN_FIELD_W;
  localparam logic [ARG_LEN_W-1:0] ARG_LEN_MAX = ARG_LEN_W'(MAX_ARG_LENGTH);
  localparam logic [ARG_LEN_W-1:0] ARG_LEN_ONE = ARG_LEN_W'(1);

  // Configuration registers.
  logic [3:0] max_args;
  logic       starttls_enable;

  // Parser state.
  phase_t               phase, phase_next;
  logic [7:0]           word_chars [0:7];
  logic [3:0]           word_length, word_length_next;
  logic [3:0]           current_command, current_command_next;
  logic [3:0]           args_done, args_done_next;
  logic [ARG_LEN_W-1:0] current_arg_length, current_arg_length_next;
  logic                 word_we;

  // Result register.
  logic                 out_valid;
  logic [1:0]           res_status, res_status_next;
  logic [3:0]           res_command;
  logic                 res_closed, res_closed_next;
  logic [11:0]          res_length, res_length_next;
  logic [3:0]           res_index, res_index_next;

  logic                 in_fire;
  logic [7:0]           ch, uc;
  logic                 delim, is_letter, line_cont;
  logic [3:0]           match_cmd;
  logic [3:0]           cmd_out;
  logic [ARG_LEN_W-1:0] alen;
  logic [LEN_WIDE_W-1:0] alen_wide;

  assign in_fire  = s_tvalid && s_tready;
  assign s_tready = !out_valid || m_tready;
  assign ch       = s_tdata;
  assign uc       = upcase(ch);
  assign delim    = (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_LF);
  assign is_letter = (uc >= "A") && (uc <= "Z");

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_args        <= 4'd10;
      starttls_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ARGS: max_args        <= cfg_data;
        REG_STARTTLS: starttls_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command word match against all stored characters in parallel.
  always_comb begin
    logic hit;
    hit       = 1'b0;
    match_cmd = CMD_NONE;
    if (word_length == SHORT_WORD_LEN) begin
      for (int k = NUM_FOUR_WORDS - 1; k >= 0; k--) begin
        hit = 1'b1;
        for (int i = 0; i < 4; i++) begin
          if (upcase(word_chars[i]) != FOUR_WORDS[k][i]) hit = 1'b0;
        end
        if (hit) match_cmd = 4'(k + 1);
      end
    end else if (word_length == LONG_WORD_LEN && starttls_enable) begin
      hit = 1'b1;
      for (int i = 0; i < 8; i++) begin
        if (upcase(word_chars[i]) != LONG_WORD[i]) hit = 1'b0;
      end
      if (hit) match_cmd = CMD_STARTTLS;
    end
  end

  // Per-byte parse step.
  always_comb begin
    phase_next              = phase;
    word_length_next        = word_length;
    current_command_next    = current_command;
    args_done_next          = args_done;
    current_arg_length_next = current_arg_length;
    word_we                 = 1'b0;
    res_status_next         = ST_MORE;
    res_closed_next         = 1'b0;
    alen                    = '0;
    res_index_next          = 4'd0;
    line_cont               = 1'b0;

    unique case (phase)
      PH_WORD: begin
        if (delim) begin
          if (match_cmd == CMD_NONE) begin
            res_status_next = ST_INVALID;
          end else begin
            current_command_next = match_cmd;
            if (ch == CH_SPACE) phase_next = PH_SPACES;
            else if (ch == CH_CR) phase_next = PH_CRSEEN;
            else res_status_next = ST_COMPLETE;
          end
        end else if (!is_letter) begin
          res_status_next = ST_INVALID;
        end else begin
          word_we = (word_length < WORD_STORE_LEN);
          if (word_length < WORD_LEN_SAT) word_length_next = word_length + 4'd1;
        end
      end
      PH_SPACES: begin
        if (ch == CH_SPACE) begin
          phase_next = PH_SPACES;
        end else if (ch == CH_CR) begin
          phase_next = PH_CRSEEN;
        end else if (ch == CH_LF) begin
          res_status_next = ST_COMPLETE;
        end else if (args_done <= max_args) begin
          phase_next              = PH_ARG;
          current_arg_length_next = ARG_LEN_ONE;
        end else begin
          res_status_next = ST_INVALID;
        end
      end
      PH_ARG: begin
        if (delim) begin
          res_closed_next         = 1'b1;
          alen                    = current_arg_length;
          res_index_next          = args_done;
          if (args_done < ARGS_SAT) args_done_next = args_done + 4'd1;
          current_arg_length_next = '0;
          if (ch == CH_SPACE) phase_next = PH_SPACES;
          else if (ch == CH_CR) phase_next = PH_CRSEEN;
          else res_status_next = ST_COMPLETE;
        end else if (current_arg_length < ARG_LEN_MAX) begin
          current_arg_length_next = current_arg_length + ARG_LEN_ONE;
        end
      end
      PH_CRSEEN: begin
        res_status_next = (ch == CH_LF) ? ST_COMPLETE : ST_INVALID;
      end
      default: begin
        res_status_next = ST_INVALID;
      end
    endcase

    // The reported command is the one in force at this byte, before a line end clears it.
    cmd_out = current_command_next;

    // End of line: clear counters; a complete AUTH command line (not its continuation) continues as argument text.
    if (res_status_next != ST_MORE) begin
      line_cont = (res_status_next == ST_COMPLETE) && (current_command_next == CMD_AUTH) &&
                  (word_length != 4'd0);
      word_length_next        = 4'd0;
      args_done_next          = 4'd0;
      current_arg_length_next = '0;
      if (line_cont) begin
        phase_next = PH_ARG;
      end else begin
        phase_next           = PH_WORD;
        current_command_next = CMD_NONE;
      end
    end
  end

  assign alen_wide       = {{ARG_LEN_FIELD_W{1'b0}}, alen};
  assign res_length_next = alen_wide[ARG_LEN_FIELD_W-1:0];

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_WORD;
      word_length        <= 4'd0;
      current_command    <= CMD_NONE;
      args_done          <= 4'd0;
      current_arg_length <= '0;
    end else if (in_fire) begin
      phase              <= phase_next;
      word_length        <= word_length_next;
      current_command    <= current_command_next;
      args_done          <= args_done_next;
      current_arg_length <= current_arg_length_next;
    end
  end

  // Stored command characters; only entries of the current word are read.
  always_ff @(posedge clk) begin
    if (in_fire && word_we) word_chars[word_length[2:0]] <= ch;
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_status  <= res_status_next;
      res_command <= cmd_out;
      res_closed  <= res_closed_next;
      res_length  <= res_length_next;
      res_index   <= res_index_next;
    end
  end

  // Drive the result stream. The command reported is the one in force at this byte.
  assign m_tvalid = out_valid;
  assign m_tuser  = res_status;
  assign m_tdata  = {3'b000, res_index, res_length, res_closed, res_command};

  // Assertions.
  `SCLP_ASSERT_SAME(a_idle_arg_fields, m_tvalid && !m_tdata[4], m_tdata[20:5] == 16'd0, "argument fields set without a closed argument")
  `SCLP_ASSERT_SAME(a_invalid_no_close, m_tvalid && (m_tuser == ST_INVALID), !m_tdata[4], "invalid line reported a closed argument")
  `SCLP_ASSERT_SAME(a_close_has_cmd, m_tvalid && m_tdata[4], m_tdata[3:0] != CMD_NONE, "argument closed without a command")
  `SCLP_ASSERT_NEXT(a_eol_clears, in_fire && (res_status_next != ST_MORE), (args_done == 4'd0) && (word_length == 4'd0) && ((phase == PH_WORD) || (phase == PH_ARG)), "line end did not clear parser state")

endmodule

`default_nettype wire
